// ===== sv/iso_pkg.sv =====
// Package with the shared constants and types of the insertion sorter.
package iso_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_WIDTH = 16;
    localparam int TDATA_W   = ((KEY_WIDTH + 7) / 8) * 8;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

// ===== sv/insertion_sorter.sv =====
// Top level of the insertion sorter: the cell chain and its load and drain control.
//
// Keys enter one item per cycle while a set is being loaded; each new key is
// compared against every cell of the chain at once and the cells above its
// place shift up by one, so the store stays in ascending order. The item with
// s_tlast closes the set. From the next cycle the chain drains toward cell 0,
// which drives the result channel directly: one key per cycle while m_tready
// is high, and s_tready is low for the whole drain. Up to 32 keys are held;
// further keys of a set are dropped and every result of that set then
// carries the overflow flag in m_tuser.
module insertion_sorter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iso_pkg::TDATA_W-1:0] s_tdata,   // [15:0] in_key
    input  logic                        s_tlast,   // in_last
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [iso_pkg::TDATA_W-1:0] m_tdata,   // [15:0] out_key
    output logic                        m_tlast,   // out_last
    output logic                        m_tuser    // overflow
);
    import iso_pkg::*;

    key_t                new_key;
    key_t                cell_key   [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_gt;
    cell_ctrl_t          ctrl;
    logic                s_accept;
    logic                m_accept;
    logic                full;
    logic                draining_reg;
    logic                draining_next;
    logic                overflow_reg;
    logic                overflow_next;

    assign new_key  = key_t'(s_tdata[KEY_WIDTH-1:0]);
    assign full     = cell_valid[CAPACITY-1];
    assign s_tready = !draining_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = draining_reg && cell_valid[0];
    assign m_accept = m_tvalid && m_tready;

    assign ctrl.insert = s_accept && !full;
    assign ctrl.drain  = m_accept;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            key_t left_key;
            logic left_valid;
            logic left_gt;
            key_t right_key;
            logic right_valid;

            if (i == 0) begin : g_first
                assign left_key   = '0;
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
            end else begin : g_inner_left
                assign left_key   = cell_key[i-1];
                assign left_valid = cell_valid[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == CAPACITY - 1) begin : g_final
                assign right_key   = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner_right
                assign right_key   = cell_key[i+1];
                assign right_valid = cell_valid[i+1];
            end

            iso_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_key     (new_key),
                .left_key    (left_key),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .right_key   (right_key),
                .right_valid (right_valid),
                .key         (cell_key[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (s_accept && full) begin
            overflow_next = 1'b1;
        end
        if (s_accept && s_tlast) begin
            draining_next = 1'b1;
        end
        if (m_accept && m_tlast) begin
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end else begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    assign m_tdata = TDATA_W'($unsigned(cell_key[0]));
    assign m_tlast = (CAPACITY == 1) ? 1'b1 : !cell_valid[CAPACITY > 1 ? 1 : 0];
    assign m_tuser = overflow_reg;

    // The valid cells always form one unbroken run starting at cell 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cell_valid & (cell_valid + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
        else $error("Valid cells are not contiguous from cell 0.");

    // Closing a set always starts the drain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> draining_reg)
        else $error("Drain did not start after the closing item.");

    // Taking the final result ends the drain with an empty chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_accept && m_tlast) |=> (!draining_reg && cell_valid == '0))
        else $error("Chain not empty after the final result.");

    // Overflow is only recorded while the chain is full during loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (overflow_reg && !draining_reg) |-> full)
        else $error("Overflow flag set while the chain is not full.");

endmodule

// ===== sv/iso_cell.sv =====
// One cell of the sorting chain: holds a key and its valid bit.
module iso_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  iso_pkg::cell_ctrl_t ctrl,
    input  iso_pkg::key_t     new_key,
    input  iso_pkg::key_t     left_key,
    input  logic              left_valid,
    input  logic              left_gt,
    input  iso_pkg::key_t     right_key,
    input  logic              right_valid,
    output iso_pkg::key_t     key,
    output logic              valid,
    output logic              gt
);
    import iso_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic take;

    // The cell takes a key when the new key sorts before its own, or when it is
    // the first empty cell. It then receives either its left neighbor's key or
    // the new key.
    assign gt   = valid_reg && (new_key < key_reg);
    assign take = gt || (!valid_reg && left_valid);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.drain) begin
            key_next   = right_key;
            valid_next = right_valid;
        end else if (ctrl.insert && take) begin
            key_next   = left_gt ? left_key : new_key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

// ===== verif/insertion_sorter_tb.sv =====
// Self-checking testbench for the insertion sorter against a sorted-set predictor.
module insertion_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iso_pkg::*;

    typedef struct {
        key_t        key;
        bit          last;
        int unsigned gap;
    } key_item_t;

    typedef struct {
        key_t key;
        bit   last;
        bit   ovf;
    } sorted_out_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;  // [15:0] in_key
    logic               s_tlast  = 1'b0; // in_last
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // [15:0] out_key
    logic               m_tlast;         // out_last
    logic               m_tuser;         // overflow

    key_item_t   key_feed[$];
    key_t        sort_store[$];
    bit          set_dropped;
    sorted_out_t expected_sorted[$];

    int unsigned feed_gap;
    int unsigned rx_pause;
    bit          rx_burst;
    int unsigned items_total;
    int unsigned keys_sent;
    int unsigned sets_closed;
    int unsigned overflow_sets;
    int unsigned results_checked;
    int unsigned errors;

    insertion_sorter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stable insert after equal keys; on the closing item the whole set comes out in order.
    task automatic insert_and_close(input key_t k, input bit last);
        int unsigned pos;
        sorted_out_t res;
        if (sort_store.size() >= CAPACITY) begin
            set_dropped = 1'b1;
        end else begin
            pos = sort_store.size();
            while (pos > 0 && k < sort_store[pos-1]) pos--;
            sort_store.insert(pos, k);
        end
        if (last) begin
            foreach (sort_store[i]) begin
                res.key  = sort_store[i];
                res.last = (i == sort_store.size() - 1);
                res.ovf  = set_dropped;
                expected_sorted.push_back(res);
            end
            sets_closed++;
            if (set_dropped) overflow_sets++;
            sort_store.delete();
            set_dropped = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        bit          v;
        int unsigned g;
        key_item_t   it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            feed_gap = 0;
        end else begin
            v = s_tvalid;
            g = feed_gap;
            if (s_tvalid && s_tready) begin
                insert_and_close(key_t'(s_tdata[KEY_WIDTH-1:0]), s_tlast);
                keys_sent++;
                v = 1'b0;
                g = (key_feed.size() > 0) ? key_feed[0].gap : 0;
            end
            if (!v) begin
                if (g > 0) begin
                    g--;
                end else if (key_feed.size() > 0) begin
                    it = key_feed.pop_front();
                    v  = 1'b1;
                    s_tdata <= TDATA_W'($unsigned(it.key));
                    s_tlast <= it.last;
                end
            end
            s_tvalid <= v;
            feed_gap = g;
        end
    end

    always @(posedge aclk) begin
        bit          r;
        int unsigned w;
        sorted_out_t want;
        key_t        got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_pause = 0;
        end else begin
            r = m_tready;
            w = rx_pause;
            if (m_tvalid && m_tready) begin
                got = key_t'(m_tdata[KEY_WIDTH-1:0]);
                if (expected_sorted.size() == 0) begin
                    $display("%0t: unexpected item key=%0d last=%0b ovf=%0b",
                             $time, got, m_tlast, m_tuser);
                    errors++;
                end else begin
                    want = expected_sorted.pop_front();
                    if (got !== want.key || m_tlast !== want.last || m_tuser !== want.ovf) begin
                        $display("%0t: mismatch expected key=%0d last=%0b ovf=%0b,",
                                 $time, want.key, want.last, want.ovf,
                                 " actual key=%0d last=%0b ovf=%0b",
                                 got, m_tlast, m_tuser);
                        errors++;
                    end
                end
                results_checked++;
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                r = 1'b0;
                if (results_checked == 40) w = 300;
                else w = rx_burst ? 0 : $urandom_range(0, 18);
            end
            if (!r) begin
                if (w > 0) w--;
                else r = 1'b1;
            end
            m_tready <= r;
            rx_pause = w;
        end
    end

    task automatic queue_key(input key_t k, input bit last, input bit burst);
        key_item_t it;
        it.key  = k;
        it.last = last;
        it.gap  = burst ? 0 : $urandom_range(0, 18);
        key_feed.push_back(it);
    endtask

    task automatic queue_list(input key_t ks[$]);
        bit burst;
        burst = ($urandom_range(0, 1) == 0);
        foreach (ks[i]) queue_key(ks[i], i == ks.size() - 1, burst);
    endtask

    function automatic key_t random_key(input int unsigned style);
        int v;
        case (style)
            0: begin
                return key_t'($urandom_range(0, 65535));
            end
            1: begin
                v = $urandom_range(0, 8);
                return key_t'(v - 4);
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return key_t'(-32768);
                    1: return key_t'(-32767);
                    2: return key_t'(-1);
                    3: return key_t'(0);
                    4: return key_t'(32766);
                    default: return key_t'(32767);
                endcase
            end
        endcase
    endfunction

    task automatic queue_random_set(input int unsigned n);
        bit          burst;
        int unsigned style;
        burst = ($urandom_range(0, 2) == 0);
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < n; i++)
            queue_key(random_key(style == 3 ? $urandom_range(0, 2) : style), i == n - 1, burst);
    endtask

    initial begin
        key_t ks[$];
        ks = '{32767};
        queue_list(ks);
        ks = '{-32768};
        queue_list(ks);
        ks = '{0, -1, 1, -32768, 32767};
        queue_list(ks);
        ks = '{7, 7, -7, 7, -7};
        queue_list(ks);
        ks = '{100, 50, 0, -50, -100};
        queue_list(ks);
        ks = '{-3, -2, -1, 0};
        queue_list(ks);

        // A set that fills the store exactly, one whose closing key is dropped, and a long one.
        queue_random_set(CAPACITY);
        queue_random_set(CAPACITY + 1);
        queue_random_set(CAPACITY + 8);
        while (key_feed.size() < 230)
            queue_random_set(($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                                         : $urandom_range(1, 12));
        items_total = key_feed.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (keys_sent < items_total || expected_sorted.size() != 0)
            @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d keys in %0d sets (%0d with dropped keys), checked %0d sorted items.",
                 keys_sent, sets_closed, overflow_sets, results_checked);
        if (errors == 0 && expected_sorted.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
